[src/array_backed_linked_list_defines.svh]
// Assertion macros shared by the linked list block.
`ifndef ARRAY_BACKED_LINKED_LIST_DEFINES_SVH
`define ARRAY_BACKED_LINKED_LIST_DEFINES_SVH

`ifndef SYNTHESIS

`define ABLL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

`define ABLL_ASSERT_NEVER(label, clk, rst_n, expr) \
    `ABLL_ASSERT(label, clk, rst_n, !(expr))

`else

`define ABLL_ASSERT(label, clk, rst_n, prop)

`define ABLL_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

[src/abll_pkg.sv]
// Shared constants, codes and control types of the linked list block.
`default_nettype none

package abll_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int IDX_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OUT_SLOT_W = 4;

    localparam logic [IDX_W-1:0] NONE_IDX = IDX_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_REMOVED   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic load_ins;
        logic load_rem;
        logic scan_next;
        logic ins_commit;
        logic full_emit;
        logic walk_next;
        logic rem_commit;
        logic nf_emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_free;
        logic scan_last;
        logic walk_valid;
        logic walk_hit;
    } dp_status_t;

endpackage

`default_nettype wire

[src/abll_datapath.sv]
// Datapath of the linked list block: slot table, list pointers, walk registers and result.
`default_nettype none
`include "array_backed_linked_list_defines.svh"

module abll_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire abll_pkg::ctrl_cmd_t                  cmd,
    input  wire logic signed [abll_pkg::VALUE_W-1:0]  value,
    output abll_pkg::dp_status_t                      stat,
    output logic                                      done,
    output logic [abll_pkg::STATUS_W-1:0]             status,
    output logic [abll_pkg::OUT_SLOT_W-1:0]           slot
);

    logic [abll_pkg::CAPACITY-1:0] used_reg;
    logic [abll_pkg::CAPACITY-1:0] used_next;
    logic [abll_pkg::VALUE_W-1:0]  slot_value_reg [abll_pkg::CAPACITY];
    logic [abll_pkg::IDX_W-1:0]    link_reg [abll_pkg::CAPACITY];

    logic [abll_pkg::IDX_W-1:0]    head_reg;
    logic [abll_pkg::IDX_W-1:0]    head_next;
    logic [abll_pkg::IDX_W-1:0]    tail_reg;
    logic [abll_pkg::IDX_W-1:0]    tail_next;

    logic [abll_pkg::IDX_W-1:0]    cur_reg;
    logic [abll_pkg::IDX_W-1:0]    cur_next;
    logic [abll_pkg::IDX_W-1:0]    prev_reg;
    logic [abll_pkg::IDX_W-1:0]    prev_next;
    logic [abll_pkg::IDX_W-1:0]    steps_reg;
    logic [abll_pkg::IDX_W-1:0]    steps_next;
    logic [abll_pkg::VALUE_W-1:0]  val_reg;
    logic [abll_pkg::VALUE_W-1:0]  val_next;

    logic                          done_reg;
    logic                          done_next;
    abll_pkg::status_t             status_reg;
    abll_pkg::status_t             status_next;
    logic [abll_pkg::OUT_SLOT_W-1:0] slot_reg;
    logic [abll_pkg::OUT_SLOT_W-1:0] slot_next;

    logic [abll_pkg::SLOT_W-1:0]   cur_idx;
    logic [abll_pkg::SLOT_W-1:0]   prev_idx;
    logic [abll_pkg::SLOT_W-1:0]   tail_idx;
    logic [abll_pkg::SLOT_W-1:0]   head_idx;
    logic [abll_pkg::IDX_W-1:0]    cur_link;
    logic                          head_none;
    logic                          tail_none;
    logic                          list_empty;

    assign cur_idx    = cur_reg[abll_pkg::SLOT_W-1:0];
    assign prev_idx   = prev_reg[abll_pkg::SLOT_W-1:0];
    assign tail_idx   = tail_reg[abll_pkg::SLOT_W-1:0];
    assign head_idx   = head_reg[abll_pkg::SLOT_W-1:0];
    assign cur_link   = link_reg[cur_idx];
    assign head_none  = (head_reg == abll_pkg::NONE_IDX);
    assign tail_none  = (tail_reg == abll_pkg::NONE_IDX);
    assign list_empty = head_none || tail_none;

    always_comb
    begin
        stat.scan_free  = !used_reg[cur_idx];
        stat.scan_last  = (cur_reg == abll_pkg::LAST_IDX);
        stat.walk_valid = (cur_reg < abll_pkg::NONE_IDX) && (steps_reg < abll_pkg::NONE_IDX)
                          && used_reg[cur_idx];
        stat.walk_hit   = stat.walk_valid && (slot_value_reg[cur_idx] == val_reg);
    end

    always_comb
    begin
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        steps_next  = steps_reg;
        val_next    = val_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        used_next   = used_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        slot_next   = slot_reg;

        if (cmd.load_ins || cmd.load_rem)
        begin
            val_next   = value;
            cur_next   = cmd.load_rem ? head_reg : '0;
            prev_next  = abll_pkg::NONE_IDX;
            steps_next = '0;
        end

        if (cmd.scan_next)
        begin
            cur_next = cur_reg + 1'b1;
        end

        if (cmd.walk_next)
        begin
            prev_next  = cur_reg;
            cur_next   = cur_link;
            steps_next = steps_reg + 1'b1;
        end

        if (cmd.ins_commit)
        begin
            used_next[cur_idx] = 1'b1;
            if (list_empty)
            begin
                head_next = cur_reg;
            end
            tail_next   = cur_reg;
            done_next   = 1'b1;
            status_next = abll_pkg::ST_INSERTED;
            slot_next   = abll_pkg::OUT_SLOT_W'(cur_reg);
        end

        if (cmd.rem_commit)
        begin
            used_next[cur_idx] = 1'b0;
            if (prev_reg == abll_pkg::NONE_IDX)
            begin
                head_next = cur_link;
                if (cur_link >= abll_pkg::NONE_IDX)
                begin
                    head_next = abll_pkg::NONE_IDX;
                    tail_next = abll_pkg::NONE_IDX;
                end
            end
            else if (tail_reg == cur_reg)
            begin
                tail_next = prev_reg;
            end
            done_next   = 1'b1;
            status_next = abll_pkg::ST_REMOVED;
            slot_next   = abll_pkg::OUT_SLOT_W'(cur_reg);
        end

        if (cmd.full_emit || cmd.nf_emit)
        begin
            done_next   = 1'b1;
            status_next = cmd.full_emit ? abll_pkg::ST_FULL : abll_pkg::ST_NOT_FOUND;
            slot_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            head_reg <= abll_pkg::NONE_IDX;
            tail_reg <= abll_pkg::NONE_IDX;
            done_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        steps_reg  <= steps_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        if (cmd.ins_commit)
        begin
            slot_value_reg[cur_idx] <= val_reg;
        end
        for (int k = 0; k < abll_pkg::CAPACITY; k++)
        begin
            if (cmd.ins_commit)
            begin
                if (abll_pkg::SLOT_W'(k) == cur_idx)
                begin
                    link_reg[k] <= abll_pkg::NONE_IDX;
                end
                else if (!list_empty && abll_pkg::SLOT_W'(k) == tail_idx)
                begin
                    link_reg[k] <= cur_reg;
                end
            end
            else if (cmd.rem_commit && prev_reg != abll_pkg::NONE_IDX
                     && abll_pkg::SLOT_W'(k) == prev_idx)
            begin
                link_reg[k] <= cur_link;
            end
        end
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign slot   = slot_reg;

    `ABLL_ASSERT(a_ends_agree, clk, rst_n, head_none == tail_none)
    `ABLL_ASSERT(a_tail_used, clk, rst_n, !tail_none |-> used_reg[tail_idx])
    `ABLL_ASSERT(a_head_used, clk, rst_n, !head_none |-> used_reg[head_idx])
    `ABLL_ASSERT(a_remove_frees, clk, rst_n, cmd.rem_commit |=> !used_reg[$past(cur_idx)])

endmodule

`default_nettype wire

[src/abll_ctrl.sv]
// Controller state machine of the linked list block.
`default_nettype none
`include "array_backed_linked_list_defines.svh"

module abll_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 action,
    input  wire abll_pkg::dp_status_t stat,
    output abll_pkg::ctrl_cmd_t       cmd,
    output logic                      busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_WALK = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == abll_pkg::ACT_REMOVE)
                    begin
                        cmd.load_rem = 1'b1;
                        state_next   = S_WALK;
                    end
                    else
                    begin
                        cmd.load_ins = 1'b1;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (stat.scan_free)
                begin
                    cmd.ins_commit = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (stat.scan_last)
                begin
                    cmd.full_emit = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_WALK:
            begin
                if (!stat.walk_valid)
                begin
                    cmd.nf_emit = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (stat.walk_hit)
                begin
                    cmd.rem_commit = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.walk_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `ABLL_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
    `ABLL_ASSERT(a_insert_end, clk, rst_n, (cmd.ins_commit || cmd.full_emit) |-> (state_reg == S_SCAN))
    `ABLL_ASSERT(a_remove_end, clk, rst_n, (cmd.rem_commit || cmd.nf_emit) |-> (state_reg == S_WALK))

endmodule

`default_nettype wire

[src/array_backed_linked_list.sv]
// Top level of the singly linked list kept in a table of sixteen slots.
//
// A transaction starts when start is high while busy is low. An insert scans the slot
// table one slot per cycle for the lowest free slot and reports that slot, or full when
// no slot is free. A remove follows the links from the head one slot read per cycle until
// it finds the matching entry or runs off the end of the list. The result is on status
// and slot, marked by done, which is high for exactly one cycle; the receiver cannot
// stall it. busy is already low in the cycle in which done is high, so the next
// transaction may start there.
`default_nettype none

module array_backed_linked_list (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 action,
    input  wire logic signed [abll_pkg::VALUE_W-1:0]  value,
    output logic                                      done,
    output logic [abll_pkg::STATUS_W-1:0]             status,
    output logic [abll_pkg::OUT_SLOT_W-1:0]           slot
);

    abll_pkg::ctrl_cmd_t  cmd;
    abll_pkg::dp_status_t stat;

    abll_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    abll_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .value  (value),
        .stat   (stat),
        .done   (done),
        .status (status),
        .slot   (slot)
    );

endmodule

`default_nettype wire

[test/abll_checker.sv]
// Checker that predicts and compares every result of the slot-table linked list.
`timescale 1ns / 1ps

module abll_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                action,
    input  logic [abll_pkg::VALUE_W-1:0]        value,
    input  logic                                done,
    input  logic [abll_pkg::STATUS_W-1:0]       status,
    input  logic [abll_pkg::OUT_SLOT_W-1:0]     slot,
    output int                                  errors,
    output int                                  pending
);

    typedef struct packed {
        abll_pkg::status_t                 status;
        logic [abll_pkg::OUT_SLOT_W-1:0]   slot;
    } list_result_t;

    logic                           slot_taken [abll_pkg::CAPACITY];
    logic [abll_pkg::VALUE_W-1:0]   slot_data  [abll_pkg::CAPACITY];
    logic [abll_pkg::IDX_W-1:0]     slot_link  [abll_pkg::CAPACITY];
    logic [abll_pkg::IDX_W-1:0]     list_head;
    logic [abll_pkg::IDX_W-1:0]     list_tail;

    list_result_t                   awaited_results [$];
    int                             fail_count;

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, exp_val, got_val);
        fail_count++;
    endtask

    task automatic clear_list();
        for (int i = 0; i < abll_pkg::CAPACITY; i++)
        begin
            slot_taken[i] = 1'b0;
            slot_data[i]  = '0;
            slot_link[i]  = '0;
        end
        list_head = abll_pkg::NONE_IDX;
        list_tail = abll_pkg::NONE_IDX;
    endtask

    task automatic predict_insert(
        input  logic [abll_pkg::VALUE_W-1:0] v,
        output list_result_t                 r
    );
        int                           free_idx;
        logic [abll_pkg::SLOT_W-1:0]  pos;
        free_idx = abll_pkg::CAPACITY;
        for (int i = abll_pkg::CAPACITY - 1; i >= 0; i--)
        begin
            if (!slot_taken[i])
            begin
                free_idx = i;
            end
        end
        if (free_idx == abll_pkg::CAPACITY)
        begin
            r.status = abll_pkg::ST_FULL;
            r.slot   = '0;
        end
        else
        begin
            pos = abll_pkg::SLOT_W'(free_idx);
            slot_taken[pos] = 1'b1;
            slot_data[pos]  = v;
            slot_link[pos]  = abll_pkg::NONE_IDX;
            if (list_head >= abll_pkg::NONE_IDX || list_tail >= abll_pkg::NONE_IDX)
            begin
                list_head = abll_pkg::IDX_W'(free_idx);
            end
            else
            begin
                slot_link[list_tail[abll_pkg::SLOT_W-1:0]] = abll_pkg::IDX_W'(free_idx);
            end
            list_tail = abll_pkg::IDX_W'(free_idx);
            r.status = abll_pkg::ST_INSERTED;
            r.slot   = abll_pkg::OUT_SLOT_W'(free_idx);
        end
    endtask

    task automatic predict_remove(
        input  logic [abll_pkg::VALUE_W-1:0] v,
        output list_result_t                 r
    );
        logic [abll_pkg::IDX_W-1:0]   prev_idx;
        logic [abll_pkg::IDX_W-1:0]   cur_idx;
        logic [abll_pkg::SLOT_W-1:0]  cur_pos;
        int                           steps;
        bit                           hit;
        prev_idx = abll_pkg::NONE_IDX;
        cur_idx  = list_head;
        cur_pos  = cur_idx[abll_pkg::SLOT_W-1:0];
        steps    = 0;
        hit      = 1'b0;
        while (!hit && cur_idx < abll_pkg::NONE_IDX && steps < abll_pkg::CAPACITY
               && slot_taken[cur_idx[abll_pkg::SLOT_W-1:0]])
        begin
            cur_pos = cur_idx[abll_pkg::SLOT_W-1:0];
            if (slot_data[cur_pos] == v)
            begin
                hit = 1'b1;
            end
            else
            begin
                prev_idx = cur_idx;
                cur_idx  = slot_link[cur_pos];
                steps++;
            end
        end
        if (!hit)
        begin
            r.status = abll_pkg::ST_NOT_FOUND;
            r.slot   = '0;
        end
        else
        begin
            cur_pos = cur_idx[abll_pkg::SLOT_W-1:0];
            if (prev_idx >= abll_pkg::NONE_IDX)
            begin
                list_head = slot_link[cur_pos];
                if (list_head >= abll_pkg::NONE_IDX)
                begin
                    list_head = abll_pkg::NONE_IDX;
                    list_tail = abll_pkg::NONE_IDX;
                end
            end
            else
            begin
                slot_link[prev_idx[abll_pkg::SLOT_W-1:0]] = slot_link[cur_pos];
                if (list_tail == cur_idx)
                begin
                    list_tail = prev_idx;
                end
            end
            slot_taken[cur_pos] = 1'b0;
            r.status = abll_pkg::ST_REMOVED;
            r.slot   = abll_pkg::OUT_SLOT_W'(cur_pos);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t exp_r;
        list_result_t new_r;
        if (!rst_n)
        begin
            clear_list();
            awaited_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("unexpected result, status", -1, status);
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    if (status !== exp_r.status)
                    begin
                        report_mismatch("status", exp_r.status, status);
                    end
                    if (slot !== exp_r.slot)
                    begin
                        report_mismatch("slot", exp_r.slot, slot);
                    end
                end
            end
            if (start && !busy)
            begin
                if (action == abll_pkg::ACT_INSERT)
                begin
                    predict_insert(value, new_r);
                end
                else
                begin
                    predict_remove(value, new_r);
                end
                awaited_results.push_back(new_r);
            end
        end
        pending <= awaited_results.size();
        errors  <= fail_count;
    end

endmodule

[test/tb_top.sv]
// Top of the testbench: clock, reset, list traffic and the final verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_RANDOM  = 1375;
    localparam int PHASE_LEN   = 80;
    localparam int QUIET_TAIL  = 150;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 24;

    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  start;
    logic                                  busy;
    logic                                  action;
    logic signed [abll_pkg::VALUE_W-1:0]   value;
    logic                                  done;
    logic [abll_pkg::STATUS_W-1:0]         status;
    logic [abll_pkg::OUT_SLOT_W-1:0]       slot;

    int                                    errors;
    int                                    pending;
    int                                    cycle_count;
    logic [abll_pkg::VALUE_W-1:0]          value_pool [6];
    bit                                    idling_on;

    array_backed_linked_list dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .action (action),
        .value  (value),
        .done   (done),
        .status (status),
        .slot   (slot)
    );

    abll_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .action  (action),
        .value   (value),
        .done    (done),
        .status  (status),
        .slot    (slot),
        .errors  (errors),
        .pending (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic act, input logic [abll_pkg::VALUE_W-1:0] v);
        start  <= 1'b1;
        action <= act;
        value  <= v;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic maybe_idle();
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    function automatic logic [abll_pkg::VALUE_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic logic [abll_pkg::VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            return value_pool[$urandom_range(0, 5)];
        end
        else if (r < 88)
        begin
            return pick_extreme();
        end
        return $urandom;
    endfunction

    initial
    begin
        int insert_pct;
        int phase;
        rst_n     = 1'b0;
        start     = 1'b0;
        action    = abll_pkg::ACT_INSERT;
        value     = '0;
        idling_on = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(abll_pkg::ACT_REMOVE, 32'd7);
        send_item(abll_pkg::ACT_INSERT, 32'h8000_0000);
        send_item(abll_pkg::ACT_INSERT, 32'h7FFF_FFFF);
        send_item(abll_pkg::ACT_INSERT, 32'hFFFF_FFFF);
        send_item(abll_pkg::ACT_INSERT, 32'h0000_0000);
        send_item(abll_pkg::ACT_REMOVE, 32'h0000_0000);
        send_item(abll_pkg::ACT_INSERT, 32'h0000_0005);
        send_item(abll_pkg::ACT_REMOVE, 32'h7FFF_FFFF);
        maybe_idle();
        send_item(abll_pkg::ACT_REMOVE, 32'h8000_0000);
        for (int i = 0; i < 14; i++)
        begin
            send_item(abll_pkg::ACT_INSERT, 32'd100 + i);
            maybe_idle();
        end
        send_item(abll_pkg::ACT_INSERT, 32'h5555_AAAA);
        send_item(abll_pkg::ACT_REMOVE, 32'd12345);

        insert_pct = 75;
        for (int k = 0; k < NUM_RANDOM; k++)
        begin
            if (k % PHASE_LEN == 0)
            begin
                phase = k / PHASE_LEN;
                insert_pct = (phase % 2 == 0) ? 30 : 72;
                for (int j = 0; j < 6; j++)
                begin
                    value_pool[j] = (phase % 3 == 1) ?
                                    abll_pkg::VALUE_W'($urandom_range(0, 3)) : $urandom;
                end
                if (phase % 3 == 0)
                begin
                    start <= 1'b0;
                    wait_drained();
                end
            end
            if (k >= NUM_RANDOM - QUIET_TAIL)
            begin
                idling_on = 1'b0;
            end
            if ($urandom_range(0, 99) < insert_pct)
            begin
                send_item(abll_pkg::ACT_INSERT, pick_value());
            end
            else
            begin
                send_item(abll_pkg::ACT_REMOVE, pick_value());
            end
            maybe_idle();
        end
        start <= 1'b0;

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
